/* hdl/vrt_pkg.sv */
// ---------------------------------------------------------------------------
// vrt_pkg: shared constants for the voxel ray traversal core
// Default geometry, fixed-point time format and queue depth.
// ---------------------------------------------------------------------------
`default_nettype none
package vrt_pkg;

	// default geometry
	localparam int MAX_CELLS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CELL_BITS_DEF = 12;

	// times: unsigned, T_FRAC fractional bits, all ones means never
	localparam int T_W    = 48;
	localparam int T_FRAC = 32;
	localparam logic [T_W-1:0] T_INF = {T_W{1'b1}};
	localparam logic [63:0] T_INF_WIDE = 64'(T_INF);

	// segments buffered between front and back
	localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

/* hdl/vrt_fifo.sv */
// ---------------------------------------------------------------------------
// vrt_fifo: small register queue
// Decouples the classify front from the walk back; valid/ready on each side.
// ---------------------------------------------------------------------------
`default_nettype none
module vrt_fifo import vrt_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/vrt_front.sv */
// ---------------------------------------------------------------------------
// vrt_front: segment intake and per-axis setup
// Registers a segment, then forms origin, start cell, direction sign,
// boundary numerator and |direction| for each axis.
// ---------------------------------------------------------------------------
`default_nettype none
module vrt_front import vrt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF,
	localparam int IN_W  = CELL_BITS + FRAC_BITS,
	localparam int NUM_W = FRAC_BITS + 1,
	localparam int DEN_W = IN_W + 1,
	localparam int AX_W  = CELL_BITS + (CELL_BITS + 1) + 2 + NUM_W + DEN_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [IN_W-1:0] start_x,
	input  wire logic signed [IN_W-1:0] start_y,
	input  wire logic signed [IN_W-1:0] start_z,
	input  wire logic signed [IN_W-1:0] end_x,
	input  wire logic signed [IN_W-1:0] end_y,
	input  wire logic signed [IN_W-1:0] end_z,
	output logic                        item_valid,
	input  wire logic                   item_ready,
	output logic [3*AX_W-1:0]           item
);
	logic [IN_W-1:0] s_s1 [3];
	logic [IN_W-1:0] e_s1 [3];
	logic            v_s1;

	assign in_ready   = !v_s1 || item_ready;
	assign item_valid = v_s1;

	// input stage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s_s1[0] <= start_x;
			s_s1[1] <= start_y;
			s_s1[2] <= start_z;
			e_s1[0] <= end_x;
			e_s1[1] <= end_y;
			e_s1[2] <= end_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// per-axis setup, everything relative to the floor of the end point
	for (genvar g = 0; g < 3; g++) begin : g_axis
		logic [FRAC_BITS-1:0] efrac, erel, sfrac;
		logic [IN_W:0]        srel;
		logic [IN_W+1:0]      dir, dabs;
		logic                 neg, pos;
		logic [NUM_W-1:0]     num;

		always_comb begin
			efrac = e_s1[g][FRAC_BITS-1:0];
			// zero fraction at the end gets a one-LSB nudge
			erel  = (efrac == '0) ? FRAC_BITS'(1) : efrac;
			srel  = {s_s1[g][IN_W-1], s_s1[g]}
				- {e_s1[g][IN_W-1], e_s1[g][IN_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
			sfrac = srel[FRAC_BITS-1:0];
			dir   = {{(IN_W + 2 - FRAC_BITS){1'b0}}, erel} - {srel[IN_W], srel};
			neg   = dir[IN_W+1];
			pos   = !neg && (dir != '0);
			dabs  = neg ? (~dir + 1'b1) : dir;
			num   = pos ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, sfrac}) : {1'b0, sfrac};
		end

		assign item[g*AX_W +: AX_W] = {e_s1[g][IN_W-1:FRAC_BITS], srel[IN_W:FRAC_BITS],
			pos, neg, num, dabs[DEN_W-1:0]};
	end
endmodule
`default_nettype wire

/* hdl/vrt_div.sv */
// ---------------------------------------------------------------------------
// vrt_div: radix-2 restoring divider for traversal times
// Computes min((num << T_FRAC) / den, T_INF), one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module vrt_div import vrt_pkg::*; #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 29
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [T_W-1:0]        quot
);
	localparam int DVD_W = NUM_W + T_FRAC;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] qd_q;   // dividend shifts out the top, quotient in the bottom
	logic [DEN_W-1:0] r_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   rsh, rdif;
	logic             ge;
	logic [63:0]      qx;

	// one subtract-and-compare step
	always_comb begin
		rsh  = {r_q, qd_q[DVD_W-1]};
		rdif = rsh - {1'b0, den_q};
		ge   = (rsh >= {1'b0, den_q});
		qx   = 64'(qd_q);
	end

	assign done = done_q;
	assign quot = (qx > T_INF_WIDE) ? T_INF : qx[T_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= {num, {T_FRAC{1'b0}}};
			r_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			qd_q <= {qd_q[DVD_W-2:0], ge};
			r_q  <= ge ? rdif[DEN_W-1:0] : rsh[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/vrt_back.sv */
// ---------------------------------------------------------------------------
// vrt_back: time setup and grid walk
// Runs the six time divisions, then steps one cell per output transfer.
// ---------------------------------------------------------------------------
`default_nettype none
module vrt_back import vrt_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF,
	localparam int IN_W  = CELL_BITS + FRAC_BITS,
	localparam int NUM_W = FRAC_BITS + 1,
	localparam int DEN_W = IN_W + 1,
	localparam int AX_W  = CELL_BITS + (CELL_BITS + 1) + 2 + NUM_W + DEN_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire logic [3*AX_W-1:0]           item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [CELL_BITS-1:0]      cell_x,
	output logic signed [CELL_BITS-1:0]      cell_y,
	output logic signed [CELL_BITS-1:0]      cell_z,
	output logic                             last_cell,
	output logic                             truncated
);
	localparam int REL_W = CELL_BITS + 3;
	localparam int CNT_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int O_NUM = DEN_W;
	localparam int O_NEG = O_NUM + NUM_W;
	localparam int O_POS = O_NEG + 1;
	localparam int O_FL  = O_POS + 1;
	localparam int O_ORG = O_FL + CELL_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_WALK = 3'b100
	} back_state_t;

	back_state_t          state_q;
	logic [REL_W-1:0]     cur_q [3];
	logic [CELL_BITS-1:0] org_q [3];
	logic                 pos_q [3];
	logic                 neg_q [3];
	logic [T_W-1:0]       tmax_q [3];
	logic [T_W-1:0]       tdel_q [3];
	logic [CNT_W-1:0]     cnt_q;

	logic                 start;
	logic [5:0]           div_done;
	logic [T_W-1:0]       tmax_div [3];
	logic [T_W-1:0]       tdel_div [3];
	logic [CELL_BITS-1:0] cell_abs [3];
	logic                 at_end, at_limit, last, take;
	logic                 lt01, lt02, lt12;
	logic [2:0]           ax;

	assign start      = (state_q == S_IDLE) && item_valid;
	assign item_ready = (state_q == S_IDLE);

	// six dividers: boundary time and cell crossing time per axis
	for (genvar g = 0; g < 3; g++) begin : g_div
		vrt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_tmax (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.num    (item[g*AX_W + O_NUM +: NUM_W]),
			.den    (item[g*AX_W +: DEN_W]),
			.done   (div_done[2*g]),
			.quot   (tmax_div[g])
		);
		vrt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_tdel (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.num    ({1'b1, {FRAC_BITS{1'b0}}}),
			.den    (item[g*AX_W +: DEN_W]),
			.done   (div_done[2*g+1]),
			.quot   (tdel_div[g])
		);
		assign cell_abs[g] = cur_q[g][CELL_BITS-1:0] + org_q[g];
	end

	// walk decisions; ties go to z, then y, then x
	always_comb begin
		at_end   = (cur_q[0] == '0) && (cur_q[1] == '0) && (cur_q[2] == '0);
		at_limit = (cnt_q == CNT_W'(MAX_CELLS - 1));
		last     = at_end || at_limit;
		lt01     = tmax_q[0] < tmax_q[1];
		lt02     = tmax_q[0] < tmax_q[2];
		lt12     = tmax_q[1] < tmax_q[2];
		ax[0]    = lt01 && lt02;
		ax[1]    = !lt01 && lt12;
		ax[2]    = !ax[0] && !ax[1];
		take     = (state_q == S_WALK) && out_ready;
	end

	assign out_valid = (state_q == S_WALK);
	assign cell_x    = cell_abs[0];
	assign cell_y    = cell_abs[1];
	assign cell_z    = cell_abs[2];
	assign last_cell = last;
	assign truncated = !at_end && at_limit;

	function automatic logic [T_W-1:0] tsat_add(input logic [T_W-1:0] a,
		input logic [T_W-1:0] b);
		logic [T_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[T_W] ? T_INF : s[T_W-1:0];
	endfunction

	// per-axis walk state
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (start) begin
				cur_q[i] <= {{2{item[i*AX_W + O_ORG - 1]}},
					item[i*AX_W + O_FL +: CELL_BITS + 1]};
				org_q[i] <= item[i*AX_W + O_ORG +: CELL_BITS];
				pos_q[i] <= item[i*AX_W + O_POS];
				neg_q[i] <= item[i*AX_W + O_NEG];
			end else if (state_q == S_DIV && (&div_done)) begin
				tmax_q[i] <= tmax_div[i];
				tdel_q[i] <= tdel_div[i];
			end else if (take && !last && ax[i]) begin
				if (pos_q[i]) begin
					cur_q[i] <= cur_q[i] + 1'b1;
				end else if (neg_q[i]) begin
					cur_q[i] <= cur_q[i] - 1'b1;
				end
				tmax_q[i] <= tsat_add(tmax_q[i], tdel_q[i]);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= '0;
					if (&div_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (out_ready) begin
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/voxel_ray_traversal_3d_core.sv */
// ---------------------------------------------------------------------------
// voxel_ray_traversal_3d_core: 3D grid walk of a line segment
// Input channel (in_valid/in_ready) takes one segment per transfer: start and
// end points in signed fixed point with FRAC_BITS fractional bits.
// Output channel (out_valid/out_ready) gives one visited cell per transfer,
// from the start cell to the cell holding the end point; last_cell marks the
// final cell, truncated marks a walk cut off after MAX_CELLS cells.
// A segment passes the intake register and the queue, then the radix-2 time
// dividers run, the times are loaded, and the walk gives one cell per cycle
// while out_ready is high. The walk unit takes the next segment only once it
// is idle again, after the last cell of the previous segment is taken.
// Up to two segments wait in the queue while the walk runs, so the input keeps
// taking items while the receiver stalls, until queue and intake are full.
// A stalled output holds its cell; the walk resumes on the next transfer.
// Reset clears the intake, queue and walk sequencer; no pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
module voxel_ray_traversal_3d_core import vrt_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF,
	localparam int IN_W  = CELL_BITS + FRAC_BITS,
	localparam int NUM_W = FRAC_BITS + 1,
	localparam int DEN_W = IN_W + 1,
	localparam int AX_W  = CELL_BITS + (CELL_BITS + 1) + 2 + NUM_W + DEN_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [IN_W-1:0]      start_x,
	input  wire logic signed [IN_W-1:0]      start_y,
	input  wire logic signed [IN_W-1:0]      start_z,
	input  wire logic signed [IN_W-1:0]      end_x,
	input  wire logic signed [IN_W-1:0]      end_y,
	input  wire logic signed [IN_W-1:0]      end_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [CELL_BITS-1:0]      cell_x,
	output logic signed [CELL_BITS-1:0]      cell_y,
	output logic signed [CELL_BITS-1:0]      cell_z,
	output logic                             last_cell,
	output logic                             truncated
);
	logic              f_valid, f_ready, q_valid, q_ready;
	logic [3*AX_W-1:0] f_item, q_item;

	vrt_front #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_z    (start_z),
		.end_x      (end_x),
		.end_y      (end_y),
		.end_z      (end_z),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	vrt_fifo #(.WIDTH(3*AX_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_item)
	);

	vrt_back #(.MAX_CELLS(MAX_CELLS), .FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.last_cell  (last_cell),
		.truncated  (truncated)
	);
endmodule
`default_nettype wire
